FILE: rtl/core/dca_pkg.sv
// Package for the dedup cache with aging: sizes, outcome codes, cell types.
// Used by dca_cell, dedup_cache_with_aging_unit and dca_checker; no dependencies.
package dca_pkg;
    localparam int Entries  = 64;
    localparam int IdxW     = $clog2(Entries);
    localparam int KeyW     = 64;
    localparam int MaxKey   = 8;

    localparam logic [2:0] OUT_EMPTY  = 3'd0;
    localparam logic [2:0] OUT_LONG   = 3'd1;
    localparam logic [2:0] OUT_HIT    = 3'd2;
    localparam logic [2:0] OUT_INSERT = 3'd3;
    localparam logic [2:0] OUT_FULL   = 3'd4;

    // command broadcast to every cell
    typedef struct packed {
        logic            lookup;   // compare phase
        logic            write;    // claim slot
        logic            bump;     // increment hit
        logic            age;      // aging pass
        logic            set_one;  // new entry gets one hit before aging
        logic [IdxW-1:0] sel;
        logic [KeyW-1:0] key;
        logic [3:0]      len;
    } t_cmd;

    // per cell status into the compare chain
    typedef struct packed {
        logic            found;
        logic [IdxW-1:0] idx;
        logic            has_free;
        logic [IdxW-1:0] free_idx;
    } t_chain;
endpackage

FILE: rtl/core/dca_cell.sv
// One cache slot: key, length, hit count and free flag, plus one link of the
// priority chain for match and free search. Depends on dca_pkg.
module dca_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [dca_pkg::IdxW-1:0]  i_my_idx,
    input  dca_pkg::t_cmd             i_cmd,
    input  dca_pkg::t_chain           i_chain,
    output dca_pkg::t_chain           o_chain,
    output logic [7:0]                o_hit
);
    logic                     r_free;
    logic [dca_pkg::KeyW-1:0] r_key;
    logic [3:0]               r_len;
    logic [7:0]               r_hit;
    logic                     w_match;
    logic                     w_me;

    assign w_me    = (i_cmd.sel == i_my_idx);
    assign w_match = !r_free && r_len == i_cmd.len && r_key == i_cmd.key;
    assign o_hit   = r_hit;

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.found && w_match) begin
            o_chain.found = 1'b1;
            o_chain.idx   = i_my_idx;
        end
        if (!i_chain.has_free && r_free) begin
            o_chain.has_free = 1'b1;
            o_chain.free_idx = i_my_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= 1'b1;
        end else begin
            if (i_cmd.write && w_me) begin
                r_free <= 1'b0;
            end else if (i_cmd.age && !r_free && r_hit == 8'd0) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && w_me) begin
            r_key <= i_cmd.key;
            r_len <= i_cmd.len;
            // with set_one the new entry ends at zero hits, as one hit halved by the same aging pass would
            r_hit <= 8'd0;
        end else if (i_cmd.bump && w_me && r_hit != 8'hFF) begin
            r_hit <= r_hit + 8'd1;
        end else if (i_cmd.age && !r_free) begin
            r_hit <= r_hit >> 1;
        end
    end
endmodule

FILE: rtl/core/dedup_cache_with_aging_unit.sv
// Top level of the dedup cache with aging: stream ports, APB register,
// sequencer and the row of dca_cell slots. Depends on dca_pkg, dca_cell.
//
// Usage: send a key on s_axis (tdata = key_bytes[63:0], key_length[71:64]).
// One result per key leaves on m_axis (tdata = outcome[2:0], slot_index[8:3],
// hit_value[16:9], aged[17], zero filled to 24 bits).
// Each key passes these steps from accept to result register: the key is
// registered, then the compare and priority search across the 64-cell chain
// is registered, then the selected cell is updated (hit bump, claim, or aging
// of all cells at once). A new key is taken once the previous one has reached
// the output register.
// age_limit sits at APB address 0, reset 25.
// Reset frees every slot, clears the live count and empties the output.
// If the receiver stalls, the result is held; one more key is accepted and
// waits after its compare until the output register is free.
module dedup_cache_with_aging_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // key_bytes[63:0], key_length[71:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // outcome, slot_index, hit_value, aged
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam int         W       = dca_pkg::IdxW;

    logic [1:0]               r_state;
    logic [6:0]               r_limit;
    logic [6:0]               r_live;
    logic [dca_pkg::KeyW-1:0] r_key;
    logic [7:0]               r_len;
    logic                     r_found;
    logic                     r_hasfree;
    logic [W-1:0]             r_idx;
    logic                     r_ovalid;
    logic [23:0]              r_odata;
    logic [dca_pkg::KeyW-1:0] w_mkey;
    logic [7:0]               w_mask_len;
    dca_pkg::t_cmd            w_cmd;
    dca_pkg::t_chain          w_chain [0:dca_pkg::Entries];
    logic [7:0]               w_hits  [0:dca_pkg::Entries-1];
    logic                     w_valid_key;
    logic                     w_ins_age;
    logic [7:0]               w_hv;
    logic [7:0]               w_cur;

    assign pready = 1'b1;
    assign prdata = {25'd0, r_limit};
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        w_mkey = s_axis_tdata[63:0];
        for (int b = 0; b < dca_pkg::MaxKey; b++) begin
            if (s_axis_tdata[71:64] <= 8'(b)) begin
                w_mkey[8*b +: 8] = 8'd0;
            end
        end
    end
    assign w_mask_len = s_axis_tdata[71:64];

    assign w_valid_key = r_len != 8'd0 && r_len <= 8'(dca_pkg::MaxKey);
    assign w_ins_age   = (r_live + 7'd1) > r_limit;
    assign w_cur       = w_hits[r_idx];

    always_comb begin
        w_cmd         = '0;
        w_cmd.key     = r_key;
        w_cmd.len     = r_len[3:0];
        w_cmd.sel     = r_idx;
        w_cmd.lookup  = (r_state == ST_LOOK);
        if (r_state == ST_UPD && w_valid_key) begin
            w_cmd.bump    = r_found;
            w_cmd.write   = !r_found && r_hasfree;
            w_cmd.set_one = w_cmd.write && w_ins_age;
            w_cmd.age     = (!r_found && !r_hasfree) || w_cmd.set_one;
        end
    end

    assign w_chain[0] = '0;
    for (genvar g = 0; g < dca_pkg::Entries; g++) begin : g_cell
        dca_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_my_idx(W'(g)),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_hit   (w_hits[g])
        );
    end

    always_comb begin
        w_hv = 8'd0;
        if (r_found) begin
            w_hv = (w_cur == 8'hFF) ? 8'hFF : w_cur + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_key <= w_mkey;
            r_len <= w_mask_len;
        end
        if (r_state == ST_LOOK) begin
            r_found   <= w_chain[dca_pkg::Entries].found;
            r_hasfree <= w_chain[dca_pkg::Entries].has_free;
            r_idx     <= w_chain[dca_pkg::Entries].found ?
                         w_chain[dca_pkg::Entries].idx :
                         w_chain[dca_pkg::Entries].free_idx;
        end
        if (r_state == ST_UPD) begin
            if (r_len == 8'd0) begin
                r_odata <= {6'd0, 1'b0, 8'd0, 6'd0, dca_pkg::OUT_EMPTY};
            end else if (!w_valid_key) begin
                r_odata <= {6'd0, 1'b0, 8'd0, 6'd0, dca_pkg::OUT_LONG};
            end else if (r_found) begin
                r_odata <= {6'd0, 1'b0, w_hv, 6'(r_idx), dca_pkg::OUT_HIT};
            end else if (!r_hasfree) begin
                r_odata <= {6'd0, 1'b1, 8'd0, 6'd0, dca_pkg::OUT_FULL};
            end else begin
                r_odata <= {6'd0, w_ins_age, 8'd0, 6'(r_idx), dca_pkg::OUT_INSERT};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_limit  <= 7'd25;
            r_live   <= 7'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0) begin
                r_limit <= pwdata[6:0];
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_state  <= ST_IDLE;
                    r_ovalid <= 1'b1;
                    if (w_cmd.age) begin
                        r_live <= 7'd0;
                    end else if (w_cmd.write) begin
                        r_live <= r_live + 7'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
    a_result_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPD |=> m_axis_tvalid) else $error("result missing");
    a_age_clears_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.age |=> r_live == 7'd0) else $error("live count not cleared");
    a_upd_output_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPD |-> !r_ovalid) else $error("result overwritten");
endmodule

FILE: verif/dca_checker.sv
// Checker for dedup_cache_with_aging_unit: watches the key and result streams and
// the APB port, predicts each result and compares it. Depends on dca_pkg.
`timescale 1ns / 100ps
module dca_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_hits,
    output int          o_inserts,
    output int          o_full,
    output int          o_aged
);
    // packed from the top bit down: aged, hit_value, slot_index, outcome
    typedef struct packed {
        logic       aged;
        logic [7:0] hits;
        logic [5:0] slot;
        logic [2:0] outcome;
    } t_lookup_res;

    logic        slot_free [dca_pkg::Entries];
    logic [63:0] slot_key  [dca_pkg::Entries];
    logic [3:0]  slot_len  [dca_pkg::Entries];
    logic [7:0]  slot_hits [dca_pkg::Entries];
    int          live;
    logic [6:0]  limit;
    t_lookup_res lookup_q[$];

    function automatic void age_slots();
        for (int i = 0; i < dca_pkg::Entries; i++) begin
            if (!slot_free[i]) begin
                if (slot_hits[i] == 0) slot_free[i] = 1'b1;
                else slot_hits[i] = slot_hits[i] >> 1;
            end
        end
        live = 0;
    endfunction

    function automatic t_lookup_res predict_lookup(logic [63:0] key, logic [7:0] len);
        t_lookup_res r;
        int          match;
        int          free_at;
        r = '0;
        match = -1;
        free_at = -1;
        if (len == 0) begin
            r.outcome = dca_pkg::OUT_EMPTY;
        end else if (len > dca_pkg::MaxKey) begin
            r.outcome = dca_pkg::OUT_LONG;
        end else begin
            if (len < 8) key = key & ((64'd1 << (8 * len)) - 64'd1);
            for (int i = 0; i < dca_pkg::Entries; i++) begin
                if (slot_free[i]) begin
                    if (free_at < 0) free_at = i;
                end else if (match < 0 && slot_len[i] == len[3:0] && slot_key[i] == key) begin
                    match = i;
                end
            end
            if (match >= 0) begin
                if (slot_hits[match] != 8'hFF) slot_hits[match]++;
                r.outcome = dca_pkg::OUT_HIT;
                r.slot = match[5:0];
                r.hits = slot_hits[match];
            end else if (free_at < 0) begin
                age_slots();
                r.outcome = dca_pkg::OUT_FULL;
                r.aged = 1'b1;
            end else begin
                slot_free[free_at] = 1'b0;
                slot_key[free_at] = key;
                slot_len[free_at] = len[3:0];
                slot_hits[free_at] = 8'd0;
                live++;
                if (live > limit) begin
                    slot_hits[free_at] = 8'd1;
                    age_slots();
                    r.aged = 1'b1;
                end
                r.outcome = dca_pkg::OUT_INSERT;
                r.slot = free_at[5:0];
                r.hits = slot_hits[free_at];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_res exp_r;
        t_lookup_res got;
        if (!i_rst_n) begin
            for (int i = 0; i < dca_pkg::Entries; i++) begin
                slot_free[i] = 1'b1;
                slot_key[i] = '0;
                slot_len[i] = '0;
                slot_hits[i] = '0;
            end
            live = 0;
            limit = 7'd25;
            lookup_q.delete();
            o_fail_count = 0;
            o_hits = 0;
            o_inserts = 0;
            o_full = 0;
            o_aged = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0) limit = pwdata[6:0];
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[17:0];
                if (lookup_q.size() == 0) begin
                    $error("unexpected item: %h", got);
                    o_fail_count++;
                end else begin
                    exp_r = lookup_q.pop_front();
                    if (got.outcome != exp_r.outcome) begin
                        $error("outcome exp %0d got %0d", exp_r.outcome, got.outcome);
                        o_fail_count++;
                    end
                    if (got.slot != exp_r.slot) begin
                        $error("slot_index exp %0d got %0d", exp_r.slot, got.slot);
                        o_fail_count++;
                    end
                    if (got.hits != exp_r.hits) begin
                        $error("hit_value exp %0d got %0d", exp_r.hits, got.hits);
                        o_fail_count++;
                    end
                    if (got.aged != exp_r.aged) begin
                        $error("aged exp %0d got %0d", exp_r.aged, got.aged);
                        o_fail_count++;
                    end
                    if (exp_r.outcome == dca_pkg::OUT_HIT) o_hits++;
                    if (exp_r.outcome == dca_pkg::OUT_INSERT) o_inserts++;
                    if (exp_r.outcome == dca_pkg::OUT_FULL) o_full++;
                    if (exp_r.aged) o_aged++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                lookup_q.push_back(predict_lookup(s_axis_tdata[63:0], s_axis_tdata[71:64]));
        end
        o_pending = lookup_q.size();
    end
endmodule

FILE: verif/tb_dedup_cache_with_aging_unit.sv
// Testbench top for dedup_cache_with_aging_unit: drives keys and age_limit writes
// under varied idling; dca_checker predicts and compares. Depends on dedup_cache_with_aging_unit, dca_checker.
`timescale 1ns / 100ps
module tb_dedup_cache_with_aging_unit;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // key_bytes[63:0], key_length[71:64]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // outcome[2:0], slot_index[8:3], hit_value[16:9], aged[17]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          n_hits;
    int          n_inserts;
    int          n_full;
    int          n_aged;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [63:0] key_pool [16];
    int          pool_lens [16];

    dedup_cache_with_aging_unit dut (.*);

    dca_checker checker_inst (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_hits(n_hits),
        .o_inserts(n_inserts), .o_full(n_full), .o_aged(n_aged)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_key(logic [63:0] key, logic [7:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {len, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_cache();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_age_limit(logic [6:0] value);
        drain_cache();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_burst(int count);
        int          pick;
        int          len;
        logic [63:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = $urandom_range(15);
                send_key(key_pool[len] | ({$urandom, $urandom} << (8 * pool_lens[len])),
                    8'(pool_lens[len]));
            end else if (pick < 85) begin
                len = $urandom_range(1, 8);
                key = {$urandom, $urandom};
                key = key & (64'h1 << ($urandom_range(1) ? 0 : 3));
                send_key(key, 8'(len));
            end else if (pick < 93) begin
                send_key({$urandom, $urandom}, 8'($urandom_range(9, 255)));
            end else begin
                send_key({$urandom, $urandom}, 8'd0);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 16; i++) begin
            pool_lens[i] = $urandom_range(1, 8);
            key_pool[i] = {$urandom, $urandom};
            if (pool_lens[i] < 8) key_pool[i] &= (64'd1 << (8 * pool_lens[i])) - 64'd1;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, too long, extremes, zero bytes, bytes past length, hits
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
        send_key(64'h0, 8'd9);
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 8'd8);
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 8'd8);
        send_key(64'h0, 8'd8);
        send_key(64'h0, 8'd1);
        send_key(64'h0, 8'd2);
        send_key(64'hAB00, 8'd1);
        send_key(64'h0000_0000_0000_0041, 8'd1);
        send_key(64'hFFFF_FFFF_FFFF_FF41, 8'd1);
        send_key(64'h0041, 8'd2);
        for (int i = 0; i < 10; i++) send_key(64'h0123_4567_89AB_CDEF, 8'd8);

        // age limit of zero ages on every insert; then the maximum fills the table
        write_age_limit(7'd0);
        send_key(64'h11, 8'd1);
        send_key(64'h22, 8'd1);
        send_key(64'h11, 8'd1);
        write_age_limit(7'd127);
        for (int i = 0; i < 70; i++) send_key(64'(i + 1000), 8'd4);
        for (int i = 0; i < 300; i++) send_key(64'h0123_4567_89AB_CDEF, 8'd8);
        for (int i = 0; i < 70; i++) send_key(64'(i + 1000), 8'd4);

        write_age_limit(7'd1);
        random_burst(150);
        write_age_limit(7'd64);
        send_idle_pct = 76;
        random_burst(200);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        random_burst(200);
        drain_cache();
        write_age_limit(7'd25);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        random_burst(250);
        write_age_limit(7'($urandom_range(2, 63)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_burst(250);

        drain_cache();
        repeat (20) @(posedge i_clk);
        $display("covered empty, long, hit, insert, overflow and aging outcomes: %0d hits,",
            n_hits);
        $display("%0d inserts, %0d full, %0d aging passes", n_inserts, n_full, n_aged);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
